/* src/ordered_key_value_table_top_defines.svh */
// assertion macros for the ordered key/value table
// used by the port checker only
`ifndef ORDERED_KEY_VALUE_TABLE_TOP_DEFINES_SVH
`define ORDERED_KEY_VALUE_TABLE_TOP_DEFINES_SVH

// implication checked on every rising clock edge outside reset
`define OKV_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("okv check failed");

// next-cycle implication checked outside reset
`define OKV_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("okv check failed");

`endif

/* src/okv_pkg.sv */
// ordered key/value table package: action codes, depth and widths, state codes
// no dependencies
`timescale 1ns / 1ps
package okv_pkg;
  localparam int unsigned TableDepth = 16;
  localparam int unsigned KeyWidth   = 32;
  localparam int unsigned ValueWidth = 32;

  typedef enum logic [2:0] {
    ACT_INSERT    = 3'd0,
    ACT_UPDATE    = 3'd1,
    ACT_UPSERT    = 3'd2,
    ACT_ERASE     = 3'd3,
    ACT_CONTAINS  = 3'd4,
    ACT_GET_KEY   = 3'd5,
    ACT_GET_POS   = 3'd6,
    ACT_NOP       = 3'd7
  } okv_action_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT_UP,
    ST_SHIFT_DOWN,
    ST_READ,
    ST_DONE
  } okv_state_e;
endpackage

/* src/ordered_key_value_table_top.sv */
// ordered key/value table: top level with key and value memories and sequencer
// depends on okv_pkg
// lookup and erase scan and move one slot a cycle;
// an insert then moves one slot a cycle
// throughput: one request at a time, the next taken the cycle after the result leaves
// reset: occupancy clears at once; memory contents stay undefined until written
`timescale 1ns / 1ps
module ordered_key_value_table_top #(
  parameter int unsigned TABLE_DEPTH = okv_pkg::TableDepth,
  parameter int unsigned KEY_WIDTH   = okv_pkg::KeyWidth,
  parameter int unsigned VALUE_WIDTH = okv_pkg::ValueWidth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  action_i,
  input  logic [31:0] key_i,
  input  logic [31:0] value_i,
  input  logic [3:0]  position_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        ok_o,
  output logic [31:0] found_key_o,
  output logic [31:0] found_value_o,
  output logic [4:0]  entry_count_o,
  output logic        is_empty_o
);
  import okv_pkg::*;

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

  // memories
  logic [KEY_WIDTH-1:0]   key_mem   [TABLE_DEPTH];
  logic [VALUE_WIDTH-1:0] value_mem [TABLE_DEPTH];
  logic [KEY_WIDTH-1:0]   rd_key_q;
  logic [VALUE_WIDTH-1:0] rd_value_q;
  logic                   we, wr_key_en;
  logic [AW-1:0]          wa, ra;
  logic [KEY_WIDTH-1:0]   wk;
  logic [VALUE_WIDTH-1:0] wv;

  okv_state_e state_q, state_d;
  okv_action_e act_q, act_d;
  logic [KEY_WIDTH-1:0]   key_q, key_d;
  logic [VALUE_WIDTH-1:0] val_q, val_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] idx_q, idx_d;   // slot being read (address issued last cycle)
  logic [CW-1:0] end_q, end_d;   // slot of match for erase; all ones marks the final insert write
  logic          pend_q, pend_d; // a read was issued last cycle
  logic          ok_q, ok_d;
  logic [31:0]   fk_q, fk_d, fv_q, fv_d;
  logic          ov_q, ov_d;
  logic [CW-1:0] pos_ext;

  assign pos_ext = CW'(position_i);

  // memory ports
  always_ff @(posedge clk_i) begin
    if (we) begin
      value_mem[wa] <= wv;
      if (wr_key_en) key_mem[wa] <= wk;
    end
    rd_key_q   <= key_mem[ra];
    rd_value_q <= value_mem[ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      pend_q  <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      pend_q  <= pend_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q <= act_d;
    key_q <= key_d;
    val_q <= val_d;
    idx_q <= idx_d;
    end_q <= end_d;
    ok_q  <= ok_d;
    fk_q  <= fk_d;
    fv_q  <= fv_d;
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    act_d = act_q; key_d = key_q; val_d = val_q;
    cnt_d = cnt_q; idx_d = idx_q; end_d = end_q;
    pend_d = 1'b0; ok_d = ok_q; fk_d = fk_q; fv_d = fv_q; ov_d = ov_q;
    we = 1'b0; wr_key_en = 1'b1; wa = '0; ra = '0; wk = key_q; wv = val_q;
    in_ready_o = 1'b0;
    if (ov_q && out_ready_i) ov_d = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = !ov_q;
        if (in_valid_i && !ov_q) begin
          act_d = okv_action_e'(action_i);
          key_d = key_i[KEY_WIDTH-1:0];
          val_d = value_i[VALUE_WIDTH-1:0];
          ok_d = 1'b0; fk_d = '0; fv_d = '0;
          idx_d = '0;
          if (okv_action_e'(action_i) == ACT_GET_POS) begin
            if (pos_ext < cnt_q && pos_ext < CW'(TABLE_DEPTH)) begin
              ra = AW'(pos_ext); pend_d = 1'b1; state_d = ST_READ;
            end else state_d = ST_DONE;
          end else if (okv_action_e'(action_i) == ACT_NOP) begin
            state_d = ST_DONE;
          end else if (cnt_q != '0) begin
            ra = '0; pend_d = 1'b1; state_d = ST_SCAN;
          end else begin
            state_d = ST_SCAN;
          end
        end
      end
      ST_READ: begin
        ok_d = 1'b1;
        fk_d = 32'(rd_key_q); fv_d = 32'(rd_value_q);
        state_d = ST_DONE;
      end
      ST_SCAN: begin
        // compare slot idx_q, issue next read
        if (pend_q && rd_key_q == key_q) begin
          state_d = ST_DONE;
          case (act_q)
            ACT_UPDATE, ACT_UPSERT: begin
              we = 1'b1; wr_key_en = 1'b0; wa = AW'(idx_q); ok_d = 1'b1;
            end
            ACT_ERASE: begin
              ok_d = 1'b1; end_d = idx_q;
              idx_d = idx_q + 1'b1;
              if (idx_q + 1'b1 < cnt_q) begin
                ra = AW'(idx_q + 1'b1); pend_d = 1'b1; state_d = ST_SHIFT_DOWN;
              end else cnt_d = cnt_q - 1'b1;
            end
            ACT_CONTAINS: ok_d = 1'b1;
            ACT_GET_KEY: begin
              ok_d = 1'b1; fk_d = 32'(rd_key_q); fv_d = 32'(rd_value_q);
            end
            default: ;
          endcase
        end else if (pend_q && idx_q + 1'b1 < cnt_q) begin
          idx_d = idx_q + 1'b1; ra = AW'(idx_q + 1'b1); pend_d = 1'b1;
        end else begin
          // key absent
          state_d = ST_DONE;
          if ((act_q == ACT_INSERT || act_q == ACT_UPSERT) && cnt_q < CW'(TABLE_DEPTH)) begin
            if (cnt_q == '0) begin
              we = 1'b1; wa = '0; ok_d = 1'b1; cnt_d = cnt_q + 1'b1;
            end else begin
              idx_d = cnt_q - 1'b1; ra = AW'(cnt_q - 1'b1); pend_d = 1'b1;
              state_d = ST_SHIFT_UP;
            end
          end
        end
      end
      ST_SHIFT_UP: begin
        // move slot idx_q to idx_q + 1, walking towards the newest
        we = 1'b1; wa = AW'(idx_q + 1'b1); wk = rd_key_q; wv = rd_value_q;
        if (idx_q == '0) begin
          ok_d = 1'b1; cnt_d = cnt_q + 1'b1;
          // the new pair goes into the newest slot next cycle
          state_d = ST_SHIFT_DOWN; end_d = '1;
        end else begin
          idx_d = idx_q - 1'b1; ra = AW'(idx_q - 1'b1); pend_d = 1'b1;
        end
      end
      ST_SHIFT_DOWN: begin
        if (end_q == '1 && !pend_q) begin
          // final write of the new pair into the newest slot
          we = 1'b1; wa = '0; state_d = ST_DONE;
        end else begin
          // move slot idx_q to idx_q - 1
          we = 1'b1; wa = AW'(idx_q - 1'b1); wk = rd_key_q; wv = rd_value_q;
          if (idx_q + 1'b1 < cnt_q) begin
            idx_d = idx_q + 1'b1; ra = AW'(idx_q + 1'b1); pend_d = 1'b1;
          end else begin
            cnt_d = cnt_q - 1'b1; state_d = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        ov_d = 1'b1; state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // result register
  logic [31:0] fk_out_q, fv_out_q;
  logic [CW-1:0] cnt_out_q;
  always_ff @(posedge clk_i) begin
    if (state_q == ST_DONE) begin
      cnt_out_q <= cnt_q;
      fk_out_q <= fk_q;
      fv_out_q <= fv_q;
    end
  end
  logic ok_out_q;
  always_ff @(posedge clk_i) if (state_q == ST_DONE) ok_out_q <= ok_q;

  assign out_valid_o   = ov_q;
  assign ok_o          = ok_out_q;
  assign found_key_o   = fk_out_q;
  assign found_value_o = fv_out_q;
  assign entry_count_o = 5'(cnt_out_q);
  assign is_empty_o    = (cnt_out_q == '0);
endmodule

/* src/okv_checker.sv */
// port checker for the ordered key/value table, bound to the top level
// depends on ordered_key_value_table_top_defines.svh
`timescale 1ns / 1ps
`include "ordered_key_value_table_top_defines.svh"
module okv_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic        ok_o,
  input logic [31:0] found_key_o,
  input logic [4:0]  entry_count_o,
  input logic        is_empty_o
);
  // empty flag agrees with the count
  `OKV_ASSERT_IMP(a_empty, clk_i, rst_ni, out_valid_o, is_empty_o == (entry_count_o == 5'd0))
  // no new request while a result waits
  `OKV_ASSERT_IMP(a_one, clk_i, rst_ni, out_valid_o, !in_ready_o)
  // a waiting result holds
  `OKV_ASSERT_NEXT(a_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(ok_o))
  // failed requests return zero key
  `OKV_ASSERT_IMP(a_zero, clk_i, rst_ni, out_valid_o && !ok_o, found_key_o == 32'd0)
endmodule

bind ordered_key_value_table_top okv_checker u_okv_checker (.*);
